// File: sv/line_cache_over_sector_buffer_assert.svh
// assertion macros used by the checker file
`ifndef LINE_CACHE_OVER_SECTOR_BUFFER_ASSERT_SVH
`define LINE_CACHE_OVER_SECTOR_BUFFER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define LCSB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcsb check failed");

// next-cycle implication, disabled while reset is asserted
`define LCSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcsb check failed");

`endif

// File: sv/lcsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsb_pkg
// Shared sizes, codes and types of the line cache over a sector buffer.
// ----------------------------------------------------------------------------
package lcsb_pkg;

    // geometry
    localparam int LINES        = 16;
    localparam int SLOT_W       = $clog2(LINES);
    localparam int LINE_BYTES   = 8;
    localparam int OFF_W        = $clog2(LINE_BYTES);
    localparam int LINE_W       = LINE_BYTES * 8;
    localparam int SECTOR_BYTES = 512;
    localparam int SEC_WORDS    = SECTOR_BYTES / LINE_BYTES;
    localparam int WIDX_W       = $clog2(SEC_WORDS);
    localparam int CNT_W_SEQ    = WIDX_W + 1;
    localparam int STACK_BYTES  = 2048;
    localparam int ADDR_BITS    = 16;
    localparam int UADDR_W      = ADDR_BITS + 1;
    localparam int TAG_W        = UADDR_W - OFF_W;
    localparam int BACK_BYTES   = (1 << ADDR_BITS) + STACK_BYTES;
    localparam int NUM_SECTORS  = BACK_BYTES / SECTOR_BYTES;
    localparam int SEC_W        = $clog2(NUM_SECTORS);
    localparam int BACK_WORDS   = BACK_BYTES / LINE_BYTES;
    localparam int BACK_AW      = SEC_W + WIDX_W;
    localparam int CNT_W        = 5;
    localparam int THR_W        = 5;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(10);
    localparam logic [CNT_W_SEQ-1:0] SEQ_DONE = CNT_W_SEQ'(SEC_WORDS);

    // request codes
    typedef enum logic [2:0] {
        REQ_BYTE_RD  = 3'd0,
        REQ_BYTE_WR  = 3'd1,
        REQ_STACK_RD = 3'd2,
        REQ_STACK_WR = 3'd3,
        REQ_FLUSH    = 3'd4
    } t_req;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_LOOKUP, ST_CHOOSE, ST_ROTATE, ST_VCHK,
        ST_FSEC, ST_FANY, ST_SEEK_CHK, ST_STORE, ST_FETCH, ST_FL_RD,
        ST_FL_WR, ST_FL_NEXT, ST_ASEC, ST_FILL_RD, ST_FILL_WR, ST_ACC_RD,
        ST_ACC_WR, ST_SCAN, ST_NEXT, ST_FIN_CHK, ST_FIN_STORE, ST_INVAL,
        ST_DONE
    } t_state;

    // datapath commands
    typedef enum logic [3:0] {
        OP_NONE, OP_LATCH, OP_LOOKUP, OP_ROTATE, OP_TSEC, OP_ASEC,
        OP_STORE, OP_FETCH, OP_FL_RD, OP_FL_WR, OP_FILL_RD, OP_FILL_WR,
        OP_ACC_RD, OP_ACC_WR, OP_INC, OP_INVAL
    } t_dp_op;

    // datapath status toward the controller
    typedef struct packed {
        logic is_access;
        logic is_flush;
        logic hit;
        logic need_rot;
        logic slot_vd;
        logic slot_last;
        logic any_sec;
        logic buf_match;
        logic buf_dirty;
        logic cnt_done;
    } t_dp_status;

    // saturating transfer count increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

endpackage

// File: sv/line_cache_over_sector_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_cache_over_sector_buffer
// Sixteen-line fully associative write-back cache over a one-sector buffer.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; one result follows on
// o_valid for a single cycle and the receiver cannot stall it, so sample the
// result ports whenever o_valid is high. busy stays high until then. Each sector
// move between buffer and backing memory walks the 64 buffer words one a cycle;
// a miss may first copy the dirty lines of its victim's sector into the buffer,
// and a flush-all grows longer with the number of dirty sectors. No clearing
// pass is needed after reset.
module line_cache_over_sector_buffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_address,
    input  logic [15:0] i_write_value,
    output logic        o_valid,
    output logic [15:0] o_read_data,
    output logic        o_hit,
    output logic [3:0]  o_slot,
    output logic [4:0]  o_lines_flushed,
    output logic [4:0]  o_sector_reads,
    output logic [4:0]  o_sector_writes,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lcsb_pkg::*;

    logic [THR_W-1:0] r_thr;
    t_dp_op           op;
    t_dp_status       st;

    // threshold register, single entry, selected whenever paddr bit 2 is low
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'h0 : {{(32-THR_W){1'b0}}, r_thr};

    lcsb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_st    (st),
        .o_op    (op),
        .busy    (busy),
        .o_valid (o_valid)
    );

    lcsb_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .i_req_type      (i_req_type),
        .i_address       (i_address),
        .i_write_value   (i_write_value),
        .i_thr           (r_thr),
        .o_st            (st),
        .o_read_data     (o_read_data),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_lines_flushed (o_lines_flushed),
        .o_sector_reads  (o_sector_reads),
        .o_sector_writes (o_sector_writes)
    );

endmodule

// File: sv/lcsb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsb_ctrl
// Sequencer that steps the datapath through lookup, eviction, sector
// transfers, line fill, access and flush-all.
// ----------------------------------------------------------------------------
module lcsb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  lcsb_pkg::t_dp_status  i_st,
    output lcsb_pkg::t_dp_op      o_op,
    output logic                  busy,
    output logic                  o_valid
);
    import lcsb_pkg::*;

    t_state r_state, n_state;
    logic   r_fill, n_fill;
    t_state ret_state;
    t_state after_flush;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    // where a seek returns and where a sector flush continues
    assign ret_state   = r_fill ? ST_FILL_RD : ST_FL_RD;
    assign after_flush = i_st.is_flush ? ST_NEXT : ST_ASEC;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        o_op    = OP_NONE;
        busy    = (r_state != ST_IDLE);
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_op    = OP_LATCH;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_st.is_access)     n_state = ST_LOOKUP;
                else if (i_st.is_flush) n_state = ST_SCAN;
                else                    n_state = ST_DONE;
            end
            ST_LOOKUP: begin
                o_op    = OP_LOOKUP;
                n_state = ST_CHOOSE;
            end
            ST_CHOOSE: begin
                if (i_st.hit)           n_state = ST_ACC_RD;
                else if (i_st.need_rot) n_state = ST_ROTATE;
                else                    n_state = ST_VCHK;
            end
            ST_ROTATE: begin
                o_op    = OP_ROTATE;
                n_state = ST_VCHK;
            end
            ST_VCHK: begin
                n_state = i_st.slot_vd ? ST_FSEC : ST_ASEC;
            end
            ST_FSEC: begin
                o_op    = OP_TSEC;
                n_state = ST_FANY;
            end
            ST_FANY: begin
                if (i_st.any_sec) begin
                    n_fill  = 1'b0;
                    n_state = ST_SEEK_CHK;
                end else begin
                    n_state = after_flush;
                end
            end
            ST_SEEK_CHK: begin
                if (i_st.buf_match)      n_state = ret_state;
                else if (i_st.buf_dirty) n_state = ST_STORE;
                else                     n_state = ST_FETCH;
            end
            ST_STORE: begin
                o_op = OP_STORE;
                if (i_st.cnt_done) n_state = ST_FETCH;
            end
            ST_FETCH: begin
                o_op = OP_FETCH;
                if (i_st.cnt_done) n_state = ret_state;
            end
            ST_FL_RD: begin
                o_op    = OP_FL_RD;
                n_state = ST_FL_WR;
            end
            ST_FL_WR: begin
                o_op    = OP_FL_WR;
                n_state = ST_FL_NEXT;
            end
            ST_FL_NEXT: begin
                n_state = i_st.any_sec ? ST_FL_RD : after_flush;
            end
            ST_ASEC: begin
                o_op    = OP_ASEC;
                n_fill  = 1'b1;
                n_state = ST_SEEK_CHK;
            end
            ST_FILL_RD: begin
                o_op    = OP_FILL_RD;
                n_state = ST_FILL_WR;
            end
            ST_FILL_WR: begin
                o_op    = OP_FILL_WR;
                n_state = ST_ACC_RD;
            end
            ST_ACC_RD: begin
                o_op    = OP_ACC_RD;
                n_state = ST_ACC_WR;
            end
            ST_ACC_WR: begin
                o_op    = OP_ACC_WR;
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                n_state = i_st.slot_vd ? ST_FSEC : ST_NEXT;
            end
            ST_NEXT: begin
                o_op    = OP_INC;
                n_state = i_st.slot_last ? ST_FIN_CHK : ST_SCAN;
            end
            ST_FIN_CHK: begin
                n_state = i_st.buf_dirty ? ST_FIN_STORE : ST_INVAL;
            end
            ST_FIN_STORE: begin
                o_op = OP_STORE;
                if (i_st.cnt_done) n_state = ST_INVAL;
            end
            ST_INVAL: begin
                o_op    = OP_INVAL;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: sv/lcsb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsb_dp
// Line tags and flags, line store, sector buffer, backing memory and the
// transfer counters, driven one command per cycle.
// ----------------------------------------------------------------------------
module lcsb_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lcsb_pkg::t_dp_op           i_op,
    input  logic [2:0]                 i_req_type,
    input  logic [15:0]                i_address,
    input  logic [15:0]                i_write_value,
    input  logic [lcsb_pkg::THR_W-1:0] i_thr,
    output lcsb_pkg::t_dp_status       o_st,
    output logic [15:0]                o_read_data,
    output logic                       o_hit,
    output logic [3:0]                 o_slot,
    output logic [4:0]                 o_lines_flushed,
    output logic [4:0]                 o_sector_reads,
    output logic [4:0]                 o_sector_writes
);
    import lcsb_pkg::*;

    // request registers
    logic [2:0]         r_req;
    logic [15:0]        r_val;
    logic [TAG_W-1:0]   r_tag;
    logic [OFF_W-1:0]   r_off;

    // line state
    logic [TAG_W-1:0]   r_tag_arr [LINES];
    logic [LINES-1:0]   r_valid;
    logic [LINES-1:0]   r_dirty;
    logic [SLOT_W-1:0]  r_vptr;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_hit;
    logic               r_need_rot;
    logic [CNT_W-1:0]   r_dcount;

    // sector buffer state
    logic [SEC_W-1:0]   r_sec;
    logic [SEC_W-1:0]   r_bsector;
    logic               r_bvalid;
    logic               r_bdirty;
    logic [NUM_SECTORS-1:0] r_svalid;
    logic [CNT_W_SEQ-1:0]   r_cnt;

    // flush bookkeeping and results
    logic [SLOT_W-1:0]  r_j;
    logic [WIDX_W-1:0]  r_boff;
    logic [15:0]        r_rdata;
    logic [CNT_W-1:0]   r_flushed;
    logic [CNT_W-1:0]   r_reads;
    logic [CNT_W-1:0]   r_writes;

    // memories and their read registers
    logic [LINE_W-1:0]  line_mem [LINES];
    logic [LINE_W-1:0]  buf_mem  [SEC_WORDS];
    logic [LINE_W-1:0]  back_mem [BACK_WORDS];
    logic [LINE_W-1:0]  r_line_rd;
    logic [LINE_W-1:0]  r_buf_rd;
    logic [LINE_W-1:0]  r_back_rd;
    logic               r_back_ok;

    // address split of the incoming request
    logic               in_stack;
    logic [UADDR_W-1:0] in_uaddr;

    assign in_stack = i_req_type[1];
    assign in_uaddr = in_stack
        ? {{(UADDR_W-11){1'b0}}, i_address[9:0], 1'b0}
        : {1'b0, i_address} + UADDR_W'(STACK_BYTES);

    // tag search, first free line and dirty count
    logic [LINES-1:0]   match;
    logic [SLOT_W-1:0]  match_idx;
    logic [SLOT_W-1:0]  free_idx;
    logic [CNT_W-1:0]   dirty_cnt;
    logic [LINES-1:0]   sec_match;
    logic [SLOT_W-1:0]  pick;

    always_comb begin
        match_idx = '0;
        free_idx  = '0;
        dirty_cnt = '0;
        pick      = '0;
        for (int k = 0; k < LINES; k++) begin
            match[k]     = r_valid[k] && (r_tag_arr[k] == r_tag);
            sec_match[k] = r_valid[k] && r_dirty[k]
                           && (r_tag_arr[k][TAG_W-1:WIDX_W] == r_sec);
            dirty_cnt    = dirty_cnt + CNT_W'(r_dirty[k]);
        end
        for (int k = LINES - 1; k >= 0; k--) begin
            if (match[k])     match_idx = SLOT_W'(k);
            if (!r_valid[k])  free_idx  = SLOT_W'(k);
            if (sec_match[k]) pick      = SLOT_W'(k);
        end
    end

    // rotating victim choice
    logic               allow;
    logic [SLOT_W-1:0]  rot_sel;
    logic [SLOT_W-1:0]  cand;

    assign allow = (r_dcount >= i_thr);

    always_comb begin
        rot_sel = r_vptr;
        cand    = r_vptr;
        for (int n = LINES; n >= 1; n--) begin
            cand = r_vptr + SLOT_W'(n);
            if (allow || !r_dirty[cand]) rot_sel = cand;
        end
    end

    // tag read port
    logic [SLOT_W-1:0]  trd_addr;
    logic [TAG_W-1:0]   trd_tag;

    assign trd_addr = (i_op == OP_FL_RD) ? pick : r_slot;
    assign trd_tag  = r_tag_arr[trd_addr];

    // byte and word access on the selected line
    logic [OFF_W-1:0]   off1;
    logic [7:0]         acc_lo;
    logic [7:0]         acc_hi;
    logic [15:0]        acc_old;
    logic               acc_chg;
    logic [LINE_W-1:0]  acc_word;
    logic               r_is_stack;
    logic               r_is_wr;

    assign r_is_stack = r_req[1];
    assign r_is_wr    = r_req[0];
    assign off1       = r_off + OFF_W'(1);
    assign acc_lo     = r_line_rd[{r_off, 3'b000} +: 8];
    assign acc_hi     = r_line_rd[{off1, 3'b000} +: 8];
    assign acc_old    = r_is_stack ? {acc_hi, acc_lo} : {8'h00, acc_lo};
    assign acc_chg    = r_is_stack ? (acc_old != r_val) : (acc_lo != r_val[7:0]);

    always_comb begin
        acc_word = r_line_rd;
        acc_word[{r_off, 3'b000} +: 8] = r_val[7:0];
        if (r_is_stack) acc_word[{off1, 3'b000} +: 8] = r_val[15:8];
    end

    // control and tag state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_dirty   <= '0;
            r_vptr    <= '0;
            r_bsector <= '0;
            r_bvalid  <= 1'b0;
            r_bdirty  <= 1'b0;
            r_svalid  <= '0;
            r_cnt     <= '0;
            r_flushed <= '0;
            r_reads   <= '0;
            r_writes  <= '0;
            for (int k = 0; k < LINES; k++) r_tag_arr[k] <= '0;
        end else begin
            unique case (i_op)
                OP_LATCH: begin
                    r_flushed <= '0;
                    r_reads   <= '0;
                    r_writes  <= '0;
                end
                OP_ROTATE: r_vptr <= rot_sel;
                OP_STORE: begin
                    if (r_cnt == SEQ_DONE) begin
                        r_cnt              <= '0;
                        r_writes           <= sat_inc(r_writes);
                        r_bdirty           <= 1'b0;
                        r_svalid[r_bsector] <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + CNT_W_SEQ'(1);
                    end
                end
                OP_FETCH: begin
                    if (r_cnt == SEQ_DONE) begin
                        r_cnt     <= '0;
                        r_reads   <= sat_inc(r_reads);
                        r_bsector <= r_sec;
                        r_bvalid  <= 1'b1;
                        r_bdirty  <= 1'b0;
                    end else begin
                        r_cnt <= r_cnt + CNT_W_SEQ'(1);
                    end
                end
                OP_FL_WR: begin
                    r_bdirty       <= r_bdirty | (r_buf_rd != r_line_rd);
                    r_dirty[r_j]   <= 1'b0;
                    r_flushed      <= sat_inc(r_flushed);
                end
                OP_FILL_WR: begin
                    r_tag_arr[r_slot] <= r_tag;
                    r_valid[r_slot]   <= 1'b1;
                    r_dirty[r_slot]   <= 1'b0;
                end
                OP_ACC_WR: begin
                    if (r_is_wr && acc_chg) r_dirty[r_slot] <= 1'b1;
                end
                OP_INVAL: begin
                    r_bvalid <= 1'b0;
                    r_bdirty <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // request and result registers
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LATCH: begin
                r_req   <= i_req_type;
                r_val   <= i_write_value;
                r_tag   <= in_uaddr[UADDR_W-1:OFF_W];
                r_off   <= in_uaddr[OFF_W-1:0];
                r_slot  <= '0;
                r_hit   <= 1'b0;
                r_rdata <= '0;
            end
            OP_LOOKUP: begin
                r_hit      <= |match;
                r_slot     <= (|match) ? match_idx : free_idx;
                r_need_rot <= !(|match) && (&r_valid);
                r_dcount   <= dirty_cnt;
            end
            OP_ROTATE: r_slot <= rot_sel;
            OP_TSEC:   r_sec  <= trd_tag[TAG_W-1:WIDX_W];
            OP_ASEC:   r_sec  <= r_tag[TAG_W-1:WIDX_W];
            OP_FL_RD: begin
                r_j    <= pick;
                r_boff <= trd_tag[WIDX_W-1:0];
            end
            OP_INC:    r_slot <= r_slot + SLOT_W'(1);
            OP_ACC_WR: r_rdata <= r_is_wr ? 16'h0000 : acc_old;
            default: ;
        endcase
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (i_op == OP_FILL_WR) line_mem[r_slot] <= r_buf_rd;
        else if (i_op == OP_ACC_WR && r_is_wr) line_mem[r_slot] <= acc_word;
        if (i_op == OP_FL_RD) r_line_rd <= line_mem[pick];
        else if (i_op == OP_ACC_RD) r_line_rd <= line_mem[r_slot];
    end

    // sector buffer
    logic [WIDX_W-1:0] cnt_prev;

    assign cnt_prev = r_cnt[WIDX_W-1:0] - WIDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_op == OP_FETCH && r_cnt != '0)
            buf_mem[cnt_prev] <= r_back_ok ? r_back_rd : '0;
        else if (i_op == OP_FL_WR)
            buf_mem[r_boff] <= r_line_rd;
        if (i_op == OP_STORE)
            r_buf_rd <= buf_mem[r_cnt[WIDX_W-1:0]];
        else if (i_op == OP_FL_RD)
            r_buf_rd <= buf_mem[trd_tag[WIDX_W-1:0]];
        else if (i_op == OP_FILL_RD)
            r_buf_rd <= buf_mem[r_tag[WIDX_W-1:0]];
    end

    // backing memory, sectors never written read as zero
    always_ff @(posedge i_clk) begin
        if (i_op == OP_STORE && r_cnt != '0)
            back_mem[BACK_AW'({r_bsector, cnt_prev})] <= r_buf_rd;
        if (i_op == OP_FETCH) begin
            r_back_rd <= back_mem[BACK_AW'({r_sec, r_cnt[WIDX_W-1:0]})];
            r_back_ok <= r_svalid[r_sec];
        end
    end

    // status and results
    assign o_st.is_access = !r_req[2];
    assign o_st.is_flush  = (r_req == REQ_FLUSH);
    assign o_st.hit       = r_hit;
    assign o_st.need_rot  = r_need_rot;
    assign o_st.slot_vd   = r_valid[r_slot] && r_dirty[r_slot];
    assign o_st.slot_last = (r_slot == SLOT_W'(LINES - 1));
    assign o_st.any_sec   = |sec_match;
    assign o_st.buf_match = r_bvalid && (r_bsector == r_sec);
    assign o_st.buf_dirty = r_bvalid && r_bdirty;
    assign o_st.cnt_done  = (r_cnt == SEQ_DONE);

    assign o_read_data     = r_rdata;
    assign o_hit           = r_hit;
    assign o_slot          = r_req[2] ? 4'h0 : r_slot;
    assign o_lines_flushed = r_flushed;
    assign o_sector_reads  = r_reads;
    assign o_sector_writes = r_writes;

endmodule

// File: sv/lcsb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsb_checker
// Port-level checks of the cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_cache_over_sector_buffer_assert.svh"

module lcsb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_hit,
    input logic [4:0]  o_lines_flushed,
    input logic [4:0]  o_sector_reads,
    input logic [4:0]  o_sector_writes
);

    // an accepted item holds the block busy
    `LCSB_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // a result only appears while an item is in flight
    `LCSB_ASSERT_SAME(a_valid_busy, i_clk, i_rst_n, o_valid, busy)

    // one result per item, then the block frees up
    `LCSB_ASSERT_NEXT(a_valid_single, i_clk, i_rst_n, o_valid, !o_valid && !busy)

    // a hit moves no data
    `LCSB_ASSERT_SAME(a_hit_quiet, i_clk, i_rst_n, o_valid && o_hit,
        o_lines_flushed == 5'd0 && o_sector_reads == 5'd0 && o_sector_writes == 5'd0)

endmodule

bind line_cache_over_sector_buffer lcsb_checker u_lcsb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_hit           (o_hit),
    .o_lines_flushed (o_lines_flushed),
    .o_sector_reads  (o_sector_reads),
    .o_sector_writes (o_sector_writes)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the line cache with byte, stack-word, flush and unused requests and
// checks every result against a cycle-free predictor of the lines, the
// sector buffer and the backing memory, across several eviction thresholds.
// ----------------------------------------------------------------------------
module testbench;
    import lcsb_pkg::*;

    localparam int CYCLE_LIMIT = 12000000;
    localparam int PHASE_ITEMS = 200;

    typedef struct {
        logic [15:0] read_data;
        logic        hit;
        logic [3:0]  slot;
        logic [4:0]  lines_flushed;
        logic [4:0]  sector_reads;
        logic [4:0]  sector_writes;
    } cache_result_t;

    // predictor of the cache and the queue of results it expects
    class cache_scoreboard;
        bit [13:0]   line_tag[LINES];
        bit          line_vld[LINES];
        bit          line_drt[LINES];
        bit [7:0]    line_data[LINES*LINE_BYTES];
        int          rot_ptr;
        int          recent_slot;
        int          buf_sec;
        bit          buf_vld;
        bit          buf_drt;
        bit [7:0]    buf_data[SECTOR_BYTES];
        bit [7:0]    backing[BACK_BYTES];
        int          evict_thr;
        int          n_flushed, n_reads, n_writes;
        cache_result_t pending[$];
        int          errors;

        function new();
            evict_thr = 10;
        endfunction

        function void sector_store();
            for (int k = 0; k < SECTOR_BYTES; k++)
                if (buf_sec * SECTOR_BYTES + k < BACK_BYTES)
                    backing[buf_sec*SECTOR_BYTES+k] = buf_data[k];
            n_writes++;
        endfunction

        function void sector_seek(int s);
            if (!buf_vld || buf_sec != s) begin
                if (buf_vld && buf_drt) sector_store();
                buf_drt = 0;
                for (int k = 0; k < SECTOR_BYTES; k++)
                    buf_data[k] = (s*SECTOR_BYTES + k < BACK_BYTES) ?
                                  backing[s*SECTOR_BYTES+k] : 8'd0;
                n_reads++;
                buf_sec = s;
                buf_vld = 1;
            end
        endfunction

        // copy every dirty line of sector s into the buffer
        function void sector_gather(int s);
            int off;
            for (int i = 0; i < LINES; i++) begin
                if (line_vld[i] && line_drt[i] && (line_tag[i] >> 6) == s) begin
                    off = (line_tag[i] * LINE_BYTES) % SECTOR_BYTES;
                    sector_seek(s);
                    for (int k = 0; k < LINE_BYTES; k++) begin
                        if (buf_data[off+k] != line_data[i*LINE_BYTES+k]) buf_drt = 1;
                        buf_data[off+k] = line_data[i*LINE_BYTES+k];
                    end
                    line_drt[i] = 0;
                    n_flushed++;
                end
            end
        endfunction

        function int choose_victim();
            int ndirty;
            bit allow;
            ndirty = 0;
            for (int i = 0; i < LINES; i++) begin
                if (!line_vld[i]) return i;
                if (line_drt[i]) ndirty++;
            end
            allow = ndirty >= evict_thr;
            for (int n = 0; n < LINES; n++) begin
                rot_ptr = (rot_ptr + 1) % LINES;
                if (allow || !line_drt[rot_ptr]) return rot_ptr;
            end
            return rot_ptr;
        endfunction

        function int unsigned sat5(int v);
            return v > 31 ? 31 : v;
        endfunction

        // note an accepted item and queue its expected result
        function void note_request(t_req req, bit [15:0] addr, bit [15:0] wval);
            cache_result_t r;
            int comb, tag, off, i, b0, b1, s;
            bit found, is_stack, is_wr;
            bit [15:0] old;
            r = '{default: 0};
            n_flushed = 0; n_reads = 0; n_writes = 0;
            if (req == REQ_FLUSH) begin
                for (int j = 0; j < LINES; j++)
                    if (line_vld[j] && line_drt[j]) sector_gather(line_tag[j] >> 6);
                if (buf_vld && buf_drt) sector_store();
                buf_drt = 0;
                buf_vld = 0;
            end else if (req <= REQ_STACK_WR) begin
                is_stack = req[1];
                is_wr = req[0];
                comb = is_stack ? (addr % (STACK_BYTES/2)) * 2 : addr + STACK_BYTES;
                tag = comb / LINE_BYTES;
                off = comb % LINE_BYTES;
                i = recent_slot;
                found = line_vld[i] && line_tag[i] == tag;
                if (!found) begin
                    for (i = 0; i < LINES; i++) begin
                        found = line_vld[i] && line_tag[i] == tag;
                        if (found) break;
                    end
                    if (!found) i = choose_victim();
                    recent_slot = i;
                end
                if (!found) begin
                    s = tag >> 6;
                    if (line_vld[i] && line_drt[i]) sector_gather(line_tag[i] >> 6);
                    sector_seek(s);
                    for (int k = 0; k < LINE_BYTES; k++)
                        line_data[i*LINE_BYTES+k] = buf_data[(tag*LINE_BYTES) % SECTOR_BYTES + k];
                    line_tag[i] = tag;
                    line_vld[i] = 1;
                    line_drt[i] = 0;
                end
                b0 = i*LINE_BYTES + off;
                b1 = i*LINE_BYTES + (off + 1) % LINE_BYTES;
                if (is_stack) begin
                    old = {line_data[b1], line_data[b0]};
                    if (is_wr) begin
                        if (old != wval) line_drt[i] = 1;
                        line_data[b0] = wval[7:0];
                        line_data[b1] = wval[15:8];
                    end else r.read_data = old;
                end else begin
                    old = {8'd0, line_data[b0]};
                    if (is_wr) begin
                        if (old[7:0] != wval[7:0]) line_drt[i] = 1;
                        line_data[b0] = wval[7:0];
                    end else r.read_data = old;
                end
                r.hit = found;
                r.slot = i;
                r.lines_flushed = sat5(n_flushed);
                r.sector_reads = sat5(n_reads);
                r.sector_writes = sat5(n_writes);
                pending.push_back(r);
                return;
            end
            r.lines_flushed = sat5(n_flushed);
            r.sector_reads = sat5(n_reads);
            r.sector_writes = sat5(n_writes);
            pending.push_back(r);
        endfunction

        // compare one result with the oldest expectation
        function void check_result(cache_result_t got);
            cache_result_t e;
            if (pending.size() == 0) begin
                $error("result with none expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.read_data !== e.read_data) begin
                $error("read_data exp %h got %h", e.read_data, got.read_data); errors++;
            end
            if (got.hit !== e.hit) begin
                $error("hit exp %0d got %0d", e.hit, got.hit); errors++;
            end
            if (got.slot !== e.slot) begin
                $error("slot exp %0d got %0d", e.slot, got.slot); errors++;
            end
            if (got.lines_flushed !== e.lines_flushed) begin
                $error("lines_flushed exp %0d got %0d", e.lines_flushed, got.lines_flushed);
                errors++;
            end
            if (got.sector_reads !== e.sector_reads) begin
                $error("sector_reads exp %0d got %0d", e.sector_reads, got.sector_reads);
                errors++;
            end
            if (got.sector_writes !== e.sector_writes) begin
                $error("sector_writes exp %0d got %0d", e.sector_writes, got.sector_writes);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [2:0]  i_req_type = '0;
    logic [15:0] i_address = '0;
    logic [15:0] i_write_value = '0;
    logic        o_valid;
    logic [15:0] o_read_data;
    logic        o_hit;
    logic [3:0]  o_slot;
    logic [4:0]  o_lines_flushed, o_sector_reads, o_sector_writes;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cache_scoreboard sb = new();
    int cycles = 0;
    int idle_pct = 0;
    bit [15:0] hot_addr[24];

    line_cache_over_sector_buffer DUT (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result('{o_read_data, o_hit, o_slot, o_lines_flushed,
                              o_sector_reads, o_sector_writes});
    end

    // present one item and hold it until the block takes it
    task automatic send_item(input t_req req, input bit [15:0] addr, input bit [15:0] wval);
        while (($urandom % 100) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        i_req_type <= req;
        i_address <= addr;
        i_write_value <= wval;
        start <= 1;
        do @(posedge i_clk); while (busy);
        sb.note_request(req, addr, wval);
    endtask

    // let every expected result arrive
    task automatic drain();
        start <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(input int v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= '0; pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.evict_thr = v;
        @(posedge i_clk);
    endtask

    task automatic random_item();
        int r;
        t_req req;
        bit [15:0] addr, wval;
        r = $urandom % 100;
        if (r < 3) req = REQ_FLUSH;
        else if (r < 6) req = t_req'($urandom_range(5, 7));
        else req = t_req'($urandom % 4);
        addr = ($urandom % 100 < 75) ? hot_addr[$urandom % 24] ^ ($urandom % 8)
                                     : $urandom;
        case ($urandom % 4)
            0: wval = 16'h0000;
            1: wval = 16'hFFFF;
            default: wval = $urandom;
        endcase
        send_item(req, addr, wval);
    endtask

    initial begin
        int thr_list[6] = '{10, 0, 16, 4, 12, 1};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, every request code, wrap of stack index
        send_item(REQ_BYTE_RD, 16'h0000, 16'h0000);
        send_item(REQ_BYTE_WR, 16'hFFFF, 16'hFFFF);
        send_item(REQ_BYTE_RD, 16'hFFFF, 16'h0000);
        send_item(REQ_STACK_WR, 16'd1023, 16'hA5C3);
        send_item(REQ_STACK_RD, 16'hFFFF, 16'h0000);
        send_item(REQ_STACK_RD, 16'd0, 16'h0000);
        send_item(REQ_STACK_WR, 16'd1024, 16'h5A3C);
        send_item(REQ_BYTE_WR, 16'h0000, 16'h0000);
        send_item(t_req'(3'd5), 16'h1234, 16'hFFFF);
        send_item(t_req'(3'd6), 16'hFFFF, 16'h0000);
        send_item(t_req'(3'd7), 16'h0000, 16'hFFFF);
        send_item(REQ_FLUSH, 16'hFFFF, 16'hFFFF);
        // fill every line dirty, then force evictions
        for (int k = 0; k < 18; k++)
            send_item(REQ_BYTE_WR, 16'(k * 520), 16'(k + 1));
        send_item(REQ_FLUSH, 16'h0000, 16'h0000);
        drain();

        for (int k = 0; k < 24; k++)
            hot_addr[k] = (k < 8) ? 16'($urandom % 1024) : 16'($urandom_range(0, 7) * 512
                                                             + $urandom % 64);

        for (int p = 0; p < 6; p++) begin
            if (p > 0) write_threshold(thr_list[p]);
            idle_pct = (p < 2) ? 9 : (p < 4) ? 80 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_item();
                if (p == 1 && n == PHASE_ITEMS/2) drain();
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
